>>> hw/rtl/las_pkg.sv
package las_pkg;

   localparam int MAX_QUERY  = 64;
   localparam int MAX_TARGET = 4095;
   localparam int SCORE_W    = 10;
   localparam int QPOS_W     = $clog2(MAX_QUERY + 1);
   localparam int TPOS_W     = 12;
   localparam int SYM_W      = 8;
   localparam int COST_W     = 4;
   localparam int CALC_W     = SCORE_W + 2;
   localparam int SCORE_MAX  = (1 << SCORE_W) - 1;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_MATCH_BONUS   = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_MISMATCH_COST = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_GAP_COST      = 2'd2;

   localparam logic MODE_QUERY  = 1'b0;
   localparam logic MODE_TARGET = 1'b1;

   localparam logic [COST_W-1:0] MATCH_BONUS_RST   = 4'd3;
   localparam logic [COST_W-1:0] MISMATCH_COST_RST = 4'd2;
   localparam logic [COST_W-1:0] GAP_COST_RST      = 4'd4;

   typedef struct packed {
      logic [COST_W-1:0] match_bonus;
      logic [COST_W-1:0] mismatch_cost;
      logic [COST_W-1:0] gap_cost;
   } cost_type;

   typedef struct packed {
      logic hold;
      logic clear;
      logic load;
      logic active;
   } cell_ctl_type;

   typedef struct packed {
      logic               valid;
      logic               last;
      logic [SYM_W-1:0]   sym;
      logic [SCORE_W-1:0] diag;
      logic [SCORE_W-1:0] up;
      logic [QPOS_W-1:0]  pos;
      logic [SCORE_W-1:0] best;
      logic [QPOS_W-1:0]  best_q;
      logic [TPOS_W-1:0]  best_t;
      logic [TPOS_W-1:0]  tpos;
   } token_type;

   function automatic logic signed [CALC_W-1:0] score_ext(input logic [SCORE_W-1:0] s);
      return $signed({{(CALC_W - SCORE_W){1'b0}}, s});
   endfunction

   function automatic logic signed [CALC_W-1:0] cost_ext(input logic [COST_W-1:0] c);
      return $signed({{(CALC_W - COST_W){1'b0}}, c});
   endfunction

endpackage

>>> hw/rtl/las_if.sv
interface las_req_if;
   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic [las_pkg::SYM_W-1:0] symbol;
   logic                      last;

   modport source (output valid, mode, symbol, last, input ready);
   modport sink (input valid, mode, symbol, last, output ready);
endinterface

interface las_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [las_pkg::SCORE_W-1:0] best_score;
   logic [las_pkg::QPOS_W-1:0]  query_end;
   logic [las_pkg::TPOS_W-1:0]  target_end;

   modport source (output valid, best_score, query_end, target_end, input ready);
   modport sink (input valid, best_score, query_end, target_end, output ready);
endinterface

>>> hw/rtl/local_alignment_score_top.sv
// channel   | dir | handshake     | payload
// req_ch    | in  | valid / ready | mode, symbol, last
// rsp_ch    | out | valid / ready | best_score, query_end, target_end
// csr_*     | in  | APB write/rd  | match_bonus, mismatch_cost, gap_cost
//
// A query word writes the cell at the current query length.
// A target word walks the row of MAX_QUERY cells one cell per cycle while the row
// does not hold; the next word is taken only after the previous one leaves the last cell.
// Synchronous reset restores the register defaults and clears the cell scores, the running best and the valid flags.
// A final result waits in the output register; the row holds while it is full.
module local_alignment_score_top (
   input  logic                           clock,
   input  logic                           reset,
   las_req_if.sink                        req_ch,
   las_rsp_if.source                      rsp_ch,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [las_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [las_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [las_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   las_pkg::cost_type costs_ff;
   las_pkg::cost_type costs_in;

   logic                        p_query_ff;
   logic                        p_query_in;
   logic                        p_target_ff;
   logic                        p_target_in;
   logic [las_pkg::QPOS_W-1:0]  qlen_ff;
   logic [las_pkg::QPOS_W-1:0]  qlen_in;
   logic [las_pkg::TPOS_W-1:0]  tpos_ff;
   logic [las_pkg::TPOS_W-1:0]  tpos_in;
   logic [las_pkg::SCORE_W-1:0] best_ff;
   logic [las_pkg::SCORE_W-1:0] best_in;
   logic [las_pkg::QPOS_W-1:0]  best_q_ff;
   logic [las_pkg::QPOS_W-1:0]  best_q_in;
   logic [las_pkg::TPOS_W-1:0]  best_t_ff;
   logic [las_pkg::TPOS_W-1:0]  best_t_in;
   logic                        busy_ff;
   logic                        busy_in;
   las_pkg::token_type          head_ff;
   las_pkg::token_type          head_in;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [las_pkg::SCORE_W-1:0] rsp_score_ff;
   logic [las_pkg::SCORE_W-1:0] rsp_score_in;
   logic [las_pkg::QPOS_W-1:0]  rsp_q_ff;
   logic [las_pkg::QPOS_W-1:0]  rsp_q_in;
   logic [las_pkg::TPOS_W-1:0]  rsp_t_ff;
   logic [las_pkg::TPOS_W-1:0]  rsp_t_in;

   logic                          req_acc;
   logic                          new_tgt;
   logic [las_pkg::QPOS_W-1:0]    qlen_eff;
   logic                          load_en;
   logic                          clear_en;
   logic                          stall;
   logic                          commit;
   logic                          csr_wr;
   logic [las_pkg::REG_IDX_W-1:0] csr_idx;

   las_pkg::token_type    tok [0:las_pkg::MAX_QUERY];
   las_pkg::token_type    tail;
   las_pkg::cell_ctl_type ctl [0:las_pkg::MAX_QUERY-1];

   assign req_ch.ready = !busy_ff;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign new_tgt      = !p_target_ff;
   assign qlen_eff     = p_query_ff ? qlen_ff : '0;
   assign load_en      = req_acc && (req_ch.mode == las_pkg::MODE_QUERY) &&
                         (qlen_eff < las_pkg::QPOS_W'(las_pkg::MAX_QUERY));
   assign clear_en     = req_acc && (req_ch.mode == las_pkg::MODE_TARGET) && new_tgt;

   assign tail   = tok[las_pkg::MAX_QUERY];
   assign stall  = tail.valid && tail.last && rsp_valid_ff && !rsp_ch.ready;
   assign commit = tail.valid && !stall;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[las_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      case (csr_idx)
         las_pkg::REG_MATCH_BONUS:   csr_prdata = las_pkg::CSR_DATA_W'(costs_ff.match_bonus);
         las_pkg::REG_MISMATCH_COST: csr_prdata = las_pkg::CSR_DATA_W'(costs_ff.mismatch_cost);
         las_pkg::REG_GAP_COST:      csr_prdata = las_pkg::CSR_DATA_W'(costs_ff.gap_cost);
         default:                    csr_prdata = '0;
      endcase
   end

   always_comb begin
      costs_in = costs_ff;
      if (csr_wr) begin
         case (csr_idx)
            las_pkg::REG_MATCH_BONUS:   costs_in.match_bonus   = csr_pwdata[las_pkg::COST_W-1:0];
            las_pkg::REG_MISMATCH_COST: costs_in.mismatch_cost = csr_pwdata[las_pkg::COST_W-1:0];
            las_pkg::REG_GAP_COST:      costs_in.gap_cost      = csr_pwdata[las_pkg::COST_W-1:0];
            default:                    costs_in = costs_ff;
         endcase
      end
   end

   always_comb begin
      p_query_in   = p_query_ff;
      p_target_in  = p_target_ff;
      qlen_in      = qlen_ff;
      tpos_in      = tpos_ff;
      best_in      = best_ff;
      best_q_in    = best_q_ff;
      best_t_in    = best_t_ff;
      busy_in      = busy_ff;
      head_in      = head_ff;
      head_in.valid = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_score_in = rsp_score_ff;
      rsp_q_in     = rsp_q_ff;
      rsp_t_in     = rsp_t_ff;

      if (req_acc) begin
         if (req_ch.mode == las_pkg::MODE_QUERY) begin
            p_target_in = 1'b0;
            p_query_in  = !req_ch.last;
            qlen_in     = load_en ? qlen_eff + 1'b1 : qlen_eff;
         end else begin
            p_query_in  = 1'b0;
            p_target_in = !req_ch.last;
            busy_in     = 1'b1;
            if (new_tgt) begin
               tpos_in = las_pkg::TPOS_W'(1);
            end else if (tpos_ff < las_pkg::TPOS_W'(las_pkg::MAX_TARGET)) begin
               tpos_in = tpos_ff + 1'b1;
            end
            head_in.valid  = 1'b1;
            head_in.last   = req_ch.last;
            head_in.sym    = req_ch.symbol;
            head_in.diag   = '0;
            head_in.up     = '0;
            head_in.pos    = '0;
            head_in.best   = new_tgt ? '0 : best_ff;
            head_in.best_q = new_tgt ? '0 : best_q_ff;
            head_in.best_t = new_tgt ? '0 : best_t_ff;
            head_in.tpos   = tpos_in;
         end
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (commit) begin
         busy_in   = 1'b0;
         best_in   = tail.best;
         best_q_in = tail.best_q;
         best_t_in = tail.best_t;
         if (tail.last) begin
            rsp_valid_in = 1'b1;
            rsp_score_in = tail.best;
            rsp_q_in     = tail.best_q;
            rsp_t_in     = tail.best_t;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         costs_ff.match_bonus   <= las_pkg::MATCH_BONUS_RST;
         costs_ff.mismatch_cost <= las_pkg::MISMATCH_COST_RST;
         costs_ff.gap_cost      <= las_pkg::GAP_COST_RST;
         p_query_ff   <= 1'b0;
         p_target_ff  <= 1'b0;
         qlen_ff      <= '0;
         tpos_ff      <= '0;
         best_ff      <= '0;
         best_q_ff    <= '0;
         best_t_ff    <= '0;
         busy_ff      <= 1'b0;
         head_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         costs_ff     <= costs_in;
         p_query_ff   <= p_query_in;
         p_target_ff  <= p_target_in;
         qlen_ff      <= qlen_in;
         tpos_ff      <= tpos_in;
         best_ff      <= best_in;
         best_q_ff    <= best_q_in;
         best_t_ff    <= best_t_in;
         busy_ff      <= busy_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_score_ff <= rsp_score_in;
      rsp_q_ff     <= rsp_q_in;
      rsp_t_ff     <= rsp_t_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.best_score = rsp_score_ff;
   assign rsp_ch.query_end  = rsp_q_ff;
   assign rsp_ch.target_end = rsp_t_ff;

   assign tok[0] = head_ff;

   for (genvar k = 0; k < las_pkg::MAX_QUERY; k++) begin : g_cell
      always_comb begin
         ctl[k].hold   = stall;
         ctl[k].clear  = clear_en;
         ctl[k].load   = load_en && (qlen_eff == las_pkg::QPOS_W'(k));
         ctl[k].active = las_pkg::QPOS_W'(k) < qlen_ff;
      end

      las_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl[k]),
         .costs  (costs_ff),
         .wr_sym (req_ch.symbol),
         .tok_i  (tok[k]),
         .tok_o  (tok[k+1])
      );
   end

endmodule

>>> hw/rtl/las_cell.sv
module las_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  las_pkg::cell_ctl_type     ctl,
   input  las_pkg::cost_type         costs,
   input  logic [las_pkg::SYM_W-1:0] wr_sym,
   input  las_pkg::token_type        tok_i,
   output las_pkg::token_type        tok_o
);

   logic [las_pkg::SYM_W-1:0]   qsym_ff;
   logic [las_pkg::SCORE_W-1:0] h_ff;
   logic [las_pkg::SCORE_W-1:0] h_in;
   las_pkg::token_type          tok_ff;
   las_pkg::token_type          tok_in;

   logic signed [las_pkg::CALC_W-1:0] d_diag;
   logic signed [las_pkg::CALC_W-1:0] d_left;
   logic signed [las_pkg::CALC_W-1:0] d_up;
   logic signed [las_pkg::CALC_W-1:0] v_max;
   logic [las_pkg::SCORE_W-1:0]       v_sat;
   logic [las_pkg::QPOS_W-1:0]        pos_next;
   logic                              take;

   always_comb begin
      if (qsym_ff == tok_i.sym) begin
         d_diag = las_pkg::score_ext(tok_i.diag) + las_pkg::cost_ext(costs.match_bonus);
      end else begin
         d_diag = las_pkg::score_ext(tok_i.diag) - las_pkg::cost_ext(costs.mismatch_cost);
      end
      d_left = las_pkg::score_ext(h_ff) - las_pkg::cost_ext(costs.gap_cost);
      d_up   = las_pkg::score_ext(tok_i.up) - las_pkg::cost_ext(costs.gap_cost);

      v_max = '0;
      if (d_diag > v_max) begin
         v_max = d_diag;
      end
      if (d_left > v_max) begin
         v_max = d_left;
      end
      if (d_up > v_max) begin
         v_max = d_up;
      end
      if (v_max > las_pkg::CALC_W'(las_pkg::SCORE_MAX)) begin
         v_sat = las_pkg::SCORE_W'(las_pkg::SCORE_MAX);
      end else begin
         v_sat = v_max[las_pkg::SCORE_W-1:0];
      end

      pos_next = tok_i.pos + 1'b1;
      take = (v_sat > tok_i.best) ||
             ((v_sat != '0) && (v_sat == tok_i.best) && (pos_next < tok_i.best_q));

      tok_in = tok_i;
      h_in   = h_ff;
      if (ctl.active) begin
         tok_in.diag = h_ff;
         tok_in.up   = v_sat;
         tok_in.pos  = pos_next;
         if (take) begin
            tok_in.best   = v_sat;
            tok_in.best_q = pos_next;
            tok_in.best_t = tok_i.tpos;
         end
         if (tok_i.valid) begin
            h_in = v_sat;
         end
      end
      if (ctl.clear) begin
         h_in = '0;
      end else if (ctl.hold) begin
         h_in = h_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         qsym_ff <= wr_sym;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff <= '0;
      end else begin
         h_ff <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (!ctl.hold) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

>>> tb/local_alignment_score_top_tb.sv
`timescale 1ns / 100ps

module local_alignment_score_top_tb;
   import las_pkg::*;

   localparam int CLOCK_PERIOD  = 10;
   localparam int RANDOM_WORDS  = 1180;
   localparam int PHASE_WORDS   = 160;
   localparam int SETTLE_CYCLES = MAX_QUERY + 34;
   localparam int CYCLE_LIMIT   = 2_000_000;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [QPOS_W-1:0]  query_end;
      logic [TPOS_W-1:0]  target_end;
   } alignment_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   las_req_if req_if();
   las_rsp_if rsp_if();

   local_alignment_score_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // scoring state mirrored from the block
   cost_type         costs;
   logic [SYM_W-1:0] query_mem [MAX_QUERY];
   int               query_len;
   int               column_scores [MAX_QUERY];
   int               top_score;
   int               top_query;
   int               top_target;
   int               target_pos;
   bit               query_open;
   bit               target_open;

   alignment_type expected_alignments [$];

   int errors;
   int words_sent;
   int alignments_checked;
   int settings_written;
   bit idle_on;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      int cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   function automatic int draw_gap();
      return idle_on ? int'($urandom_range(0, 16)) : 0;
   endfunction

   function automatic logic [SYM_W-1:0] pick_symbol(logic [SYM_W-1:0] base, bit narrow);
      return narrow ? SYM_W'(base + $urandom_range(0, 3)) : SYM_W'($urandom);
   endfunction

   function automatic void advance_alignment(logic mode, logic [SYM_W-1:0] sym, logic last);
      int            diag;
      int            up;
      int            left;
      int            cand;
      int            cell_score;
      alignment_type res;
      if (mode == MODE_QUERY) begin
         target_open = 1'b0;
         if (!query_open) begin
            query_len  = 0;
            query_open = 1'b1;
         end
         if (query_len < MAX_QUERY) begin
            query_mem[query_len] = sym;
            query_len++;
         end
         if (last) query_open = 1'b0;
         return;
      end
      query_open = 1'b0;
      if (!target_open) begin
         foreach (column_scores[i]) column_scores[i] = 0;
         top_score   = 0;
         top_query   = 0;
         top_target  = 0;
         target_pos  = 0;
         target_open = 1'b1;
      end
      if (target_pos < MAX_TARGET) target_pos++;
      diag = 0;
      up   = 0;
      for (int i = 0; i < query_len; i++) begin
         left = column_scores[i];
         if (query_mem[i] == sym) cand = diag + int'(costs.match_bonus);
         else cand = diag - int'(costs.mismatch_cost);
         cell_score = 0;
         if (cand > cell_score) cell_score = cand;
         if (left - int'(costs.gap_cost) > cell_score) cell_score = left - int'(costs.gap_cost);
         if (up - int'(costs.gap_cost) > cell_score) cell_score = up - int'(costs.gap_cost);
         if (cell_score > SCORE_MAX) cell_score = SCORE_MAX;
         diag             = left;
         column_scores[i] = cell_score;
         up               = cell_score;
         if (cell_score > top_score ||
             (cell_score > 0 && cell_score == top_score && i + 1 < top_query)) begin
            top_score  = cell_score;
            top_query  = i + 1;
            top_target = target_pos;
         end
      end
      if (!last) return;
      target_open    = 1'b0;
      res.score      = top_score[SCORE_W-1:0];
      res.query_end  = top_query[QPOS_W-1:0];
      res.target_end = top_target[TPOS_W-1:0];
      expected_alignments.push_back(res);
   endfunction

   task automatic send_word(logic mode, logic [SYM_W-1:0] sym, logic last);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.mode   <= mode;
      req_if.symbol <= sym;
      req_if.last   <= last;
      do @(posedge clock); while (!req_if.ready);
      advance_alignment(mode, sym, last);
      words_sent++;
   endtask

   // drain every pending result, then let the row go quiet
   task automatic settle();
      req_if.valid <= 1'b0;
      while (expected_alignments.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [COST_W-1:0] value);
      logic [CSR_DATA_W-1:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (got !== CSR_DATA_W'(value)) begin
         errors++;
         $display("%0t: register %0d readback expected %0d actual %0d",
                  $time, idx, value, got);
      end
   endtask

   task automatic set_costs(logic [COST_W-1:0] bonus, logic [COST_W-1:0] mismatch,
                            logic [COST_W-1:0] gap);
      write_reg(REG_MATCH_BONUS, bonus);
      costs.match_bonus = bonus;
      write_reg(REG_MISMATCH_COST, mismatch);
      costs.mismatch_cost = mismatch;
      write_reg(REG_GAP_COST, gap);
      costs.gap_cost = gap;
      settings_written++;
   endtask

   task automatic test_empty_query();
      send_word(MODE_TARGET, 8'h41, 1'b0);
      send_word(MODE_TARGET, 8'h00, 1'b1);
   endtask

   task automatic test_directed();
      logic [SYM_W-1:0] query_syms [5] = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h3C};
      logic [SYM_W-1:0] target_syms [5] = '{8'hFF, 8'hA5, 8'h5A, 8'h00, 8'hC3};
      foreach (query_syms[i]) send_word(MODE_QUERY, query_syms[i], i == 4);
      foreach (target_syms[i]) send_word(MODE_TARGET, target_syms[i], i == 4);
      // reuse the loaded query for a second target
      send_word(MODE_TARGET, 8'h00, 1'b0);
      send_word(MODE_TARGET, 8'hFF, 1'b0);
      send_word(MODE_TARGET, 8'hFF, 1'b0);
      send_word(MODE_TARGET, 8'hA5, 1'b1);
      // query left open, closed by the target
      send_word(MODE_QUERY, 8'h11, 1'b0);
      send_word(MODE_QUERY, 8'h22, 1'b0);
      send_word(MODE_QUERY, 8'h33, 1'b0);
      send_word(MODE_TARGET, 8'h22, 1'b0);
      send_word(MODE_TARGET, 8'h33, 1'b1);
      // target dropped by a new query
      send_word(MODE_TARGET, 8'h11, 1'b0);
      send_word(MODE_TARGET, 8'h22, 1'b0);
      send_word(MODE_QUERY, 8'h7E, 1'b0);
      send_word(MODE_QUERY, 8'h81, 1'b1);
      send_word(MODE_TARGET, 8'h7E, 1'b0);
      send_word(MODE_TARGET, 8'h81, 1'b1);
   endtask

   task automatic test_query_overflow();
      settle();
      set_costs(4'd15, 4'd0, 4'd0);
      for (int i = 0; i < MAX_QUERY + 6; i++)
         send_word(MODE_QUERY, pick_symbol(8'h01, 1'b1), i == MAX_QUERY + 5);
      for (int i = 0; i < 12; i++)
         send_word(MODE_TARGET, pick_symbol(8'h01, 1'b1), i == 11);
      settle();
      set_costs(4'd15, 4'd15, 4'd15);
      for (int i = 0; i < 12; i++)
         send_word(MODE_TARGET, pick_symbol(8'h01, 1'b1), i == 11);
   endtask

   task automatic random_alignment();
      int               kind;
      int               qlen;
      int               tlen;
      bit               narrow;
      logic [SYM_W-1:0] base;
      kind   = $urandom_range(0, 9);
      narrow = $urandom_range(0, 3) != 0;
      base   = SYM_W'($urandom);
      if (kind != 0) begin
         qlen = ($urandom_range(0, 15) == 0) ? $urandom_range(40, MAX_QUERY + 6)
                                               : $urandom_range(1, 12);
         for (int i = 0; i < qlen; i++)
            send_word(MODE_QUERY, pick_symbol(base, narrow), i == qlen - 1 && kind != 1);
      end
      tlen = $urandom_range(1, 20);
      for (int i = 0; i < tlen; i++)
         send_word(MODE_TARGET, pick_symbol(base, narrow), i == tlen - 1 && kind != 2);
   endtask

   task automatic test_random();
      int start_words;
      int phase;
      start_words = words_sent;
      phase       = 0;
      while (words_sent - start_words < RANDOM_WORDS) begin
         settle();
         case (phase)
            0: set_costs(4'd0, 4'd0, 4'd0);
            1: set_costs(4'd15, 4'd15, 4'd15);
            2: set_costs(4'd15, 4'd0, 4'd0);
            3: set_costs(4'd1, 4'd15, 4'd15);
            4: set_costs(MATCH_BONUS_RST, MISMATCH_COST_RST, GAP_COST_RST);
            default: set_costs(COST_W'($urandom), COST_W'($urandom), COST_W'($urandom));
         endcase
         idle_on = (phase % 4) != 3;
         while (words_sent - start_words < (phase + 1) * PHASE_WORDS &&
                words_sent - start_words < RANDOM_WORDS)
            random_alignment();
         phase++;
      end
      idle_on = 1'b1;
   endtask

   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall == 0) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b0;
            do @(posedge clock); while (!rsp_if.valid);
            repeat (stall - 1) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   always @(posedge clock) begin
      alignment_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_alignments.size() == 0) begin
            errors++;
            $display("%0t: unexpected word score %0d query_end %0d target_end %0d",
                     $time, rsp_if.best_score, rsp_if.query_end, rsp_if.target_end);
         end else begin
            want = expected_alignments.pop_front();
            alignments_checked++;
            if (rsp_if.best_score !== want.score) begin
               errors++;
               $display("%0t: best_score expected %0d actual %0d",
                        $time, want.score, rsp_if.best_score);
            end
            if (rsp_if.query_end !== want.query_end) begin
               errors++;
               $display("%0t: query_end expected %0d actual %0d",
                        $time, want.query_end, rsp_if.query_end);
            end
            if (rsp_if.target_end !== want.target_end) begin
               errors++;
               $display("%0t: target_end expected %0d actual %0d",
                        $time, want.target_end, rsp_if.target_end);
            end
         end
      end
   end

   initial begin
      reset         = 1'b1;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      req_if.valid  <= 1'b0;
      req_if.mode   <= MODE_QUERY;
      req_if.symbol <= '0;
      req_if.last   <= 1'b0;
      costs         = '{MATCH_BONUS_RST, MISMATCH_COST_RST, GAP_COST_RST};
      query_len     = 0;
      query_open    = 1'b0;
      target_open   = 1'b0;
      top_score     = 0;
      top_query     = 0;
      top_target    = 0;
      target_pos    = 0;
      errors             = 0;
      words_sent         = 0;
      alignments_checked = 0;
      settings_written   = 0;
      idle_on            = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_query();
      test_directed();
      test_query_overflow();
      test_random();
      settle();
      $display("Run covered %0d words and %0d checked alignments over %0d cost settings,",
               words_sent, alignments_checked, settings_written);
      $display("including query overflow, open and dropped sequences and random stalls.");
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
